// ===== rtl/core/hdt_pkg.sv =====
// Shared types and constants for the heartbeat deadline tracker.
`timescale 1ns / 1ps

package hdt_pkg;

    // Field widths
    localparam int unsigned TIME_W = 64;
    localparam int unsigned CFG_W  = 64;
    localparam int unsigned IDX_W  = 2;

    // Millisecond to nanosecond conversion
    localparam logic [TIME_W-1:0] ALL_ONES     = '1;
    localparam logic [TIME_W-1:0] NS_PER_MS    = 64'd1000000;
    localparam logic [TIME_W-1:0] MS_SAT_LIMIT = ALL_ONES / NS_PER_MS;

    // Split of the millisecond value for the two partial products
    localparam int unsigned LO_W      = 32;
    localparam int unsigned MS_W      = $clog2(MS_SAT_LIMIT + 1);
    localparam int unsigned HI_W      = MS_W - LO_W;
    localparam int unsigned CONST_W   = $clog2(NS_PER_MS + 1);
    localparam int unsigned PROD_LO_W = LO_W + CONST_W;
    localparam int unsigned PROD_HI_W = HI_W + CONST_W;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_RECEIVE = 2'd1,
        ACT_PING    = 2'd2,
        ACT_POLL    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        DEC_WAIT       = 2'd0,
        DEC_SEND_PING  = 2'd1,
        DEC_HB_EXPIRED = 2'd2,
        DEC_RX_EXPIRED = 2'd3
    } decision_t;

    typedef enum logic [IDX_W-1:0] {
        REG_PING_INTERVAL = 2'd0,
        REG_HB_TIMEOUT    = 2'd1,
        REG_RX_TIMEOUT    = 2'd2,
        REG_UNUSED        = 2'd3
    } cfg_index_t;

endpackage

// ===== rtl/core/hdt_item_if.sv =====
// Input channel: action and current time.
`timescale 1ns / 1ps

interface hdt_item_if;
    logic                          valid;
    logic                          ready;
    hdt_pkg::action_t              action;
    logic [hdt_pkg::TIME_W-1:0]    now_time_ns;

    modport source (output valid, output action, output now_time_ns, input ready);
    modport sink   (input valid, input action, input now_time_ns, output ready);
endinterface

// ===== rtl/core/hdt_result_if.sv =====
// Result channel: poll decision and wake time.
`timescale 1ns / 1ps

interface hdt_result_if;
    logic                          valid;
    logic                          ready;
    hdt_pkg::decision_t            decision;
    logic [hdt_pkg::TIME_W-1:0]    wake_time_ns;

    modport source (output valid, output decision, output wake_time_ns, input ready);
    modport sink   (input valid, input decision, input wake_time_ns, output ready);
endinterface

// ===== rtl/core/heartbeat_deadline_tracker_unit.sv =====
// Heartbeat deadline tracker: three saturating nanosecond deadlines and poll logic.
`timescale 1ns / 1ps

// One transaction per cycle is taken on item while item.ready is high; a poll
// gives its result on the result channel after the input register and then the
// result register, and start, receive and ping transactions give no result. Each
// configuration write converts milliseconds to nanoseconds in a two-stage
// multiply-and-sum path; item.ready is low while that conversion completes.
// item.ready also drops while a poll waits in the input register behind a
// result that has not been taken.
module heartbeat_deadline_tracker_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hdt_pkg::IDX_W-1:0]         cfg_index,
    input  logic [hdt_pkg::CFG_W-1:0]         cfg_wdata,
    hdt_item_if.sink                          item,
    hdt_result_if.source                      result
);

    localparam int unsigned TW = hdt_pkg::TIME_W;

    // Configuration conversion pipeline
    logic                               cv_valid_reg;
    hdt_pkg::cfg_index_t                cv_index_reg;
    logic [hdt_pkg::PROD_LO_W-1:0]      cv_lo_reg;
    logic [hdt_pkg::PROD_HI_W-1:0]      cv_hi_reg;
    logic                               cv_sat_reg;
    logic                               cv_zero_reg;
    logic [TW-1:0]                      cv_span;

    // Interval spans in nanoseconds
    logic [TW-1:0]                      ping_span_reg;
    logic [TW-1:0]                      hb_span_reg;
    logic [TW-1:0]                      rx_span_reg;

    // Deadlines
    logic [TW-1:0]                      next_ping_reg;
    logic [TW-1:0]                      hb_expiry_reg;
    logic [TW-1:0]                      rx_expiry_reg;

    // Input register
    logic                               s1_valid_reg;
    hdt_pkg::action_t                   s1_action_reg;
    logic [TW-1:0]                      s1_now_reg;
    logic                               s1_poll;
    logic                               s1_advance;
    logic                               item_accept;

    // Result register
    logic                               out_valid_reg;
    logic                               out_valid_next;
    hdt_pkg::decision_t                 out_decision_reg;
    hdt_pkg::decision_t                 dec_next;
    logic [TW-1:0]                      out_wake_reg;
    logic [TW-1:0]                      wake_next;

    // Deadline candidates
    logic [TW:0]                        ping_sum;
    logic [TW:0]                        hb_sum;
    logic [TW:0]                        rx_sum;
    logic [TW-1:0]                      ping_deadline;
    logic [TW-1:0]                      hb_deadline;
    logic [TW-1:0]                      rx_deadline;
    logic [TW-1:0]                      min_ph;

    // Launch partial products straight from the write data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_valid_reg <= 1'b0;
        end
        else
        begin
            cv_valid_reg <= cfg_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cfg_we)
        begin
            cv_index_reg <= hdt_pkg::cfg_index_t'(cfg_index);
            cv_lo_reg    <= hdt_pkg::PROD_LO_W'(cfg_wdata[hdt_pkg::LO_W-1:0])
                            * hdt_pkg::PROD_LO_W'(hdt_pkg::NS_PER_MS);
            cv_hi_reg    <= hdt_pkg::PROD_HI_W'(cfg_wdata[hdt_pkg::MS_W-1:hdt_pkg::LO_W])
                            * hdt_pkg::PROD_HI_W'(hdt_pkg::NS_PER_MS);
            cv_sat_reg   <= (cfg_wdata > hdt_pkg::MS_SAT_LIMIT);
            cv_zero_reg  <= (cfg_wdata == '0);
        end
    end

    // Sum partial products, saturate past the representable range
    always_comb
    begin
        if (cv_sat_reg)
        begin
            cv_span = hdt_pkg::ALL_ONES;
        end
        else
        begin
            cv_span = {cv_hi_reg[TW-hdt_pkg::LO_W-1:0], hdt_pkg::LO_W'(0)}
                      + TW'(cv_lo_reg);
        end
    end

    // Commit converted spans; a zero receive timeout means never
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ping_span_reg <= '0;
            hb_span_reg   <= '0;
            rx_span_reg   <= hdt_pkg::ALL_ONES;
        end
        else if (cv_valid_reg)
        begin
            unique case (cv_index_reg)
                hdt_pkg::REG_PING_INTERVAL: ping_span_reg <= cv_span;
                hdt_pkg::REG_HB_TIMEOUT:    hb_span_reg   <= cv_span;
                hdt_pkg::REG_RX_TIMEOUT:
                begin
                    rx_span_reg <= cv_zero_reg ? hdt_pkg::ALL_ONES : cv_span;
                end
                default: ;
            endcase
        end
    end

    // Handshake: a poll may not leave the input register while a result is stalled
    assign s1_poll     = (s1_action_reg == hdt_pkg::ACT_POLL);
    assign s1_advance  = s1_valid_reg && !(s1_poll && out_valid_reg && !result.ready);
    assign item.ready  = (!s1_valid_reg || s1_advance) && !cv_valid_reg;
    assign item_accept = item.valid && item.ready;

    // Hold the accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_action_reg <= item.action;
            s1_now_reg    <= item.now_time_ns;
        end
    end

    // Saturating deadline adds
    always_comb
    begin
        ping_sum = {1'b0, s1_now_reg} + {1'b0, ping_span_reg};
        hb_sum   = {1'b0, s1_now_reg} + {1'b0, hb_span_reg};
        rx_sum   = {1'b0, s1_now_reg} + {1'b0, rx_span_reg};
        ping_deadline = (ping_sum[TW] || ping_span_reg == hdt_pkg::ALL_ONES)
                        ? hdt_pkg::ALL_ONES : ping_sum[TW-1:0];
        hb_deadline   = (hb_sum[TW] || hb_span_reg == hdt_pkg::ALL_ONES)
                        ? hdt_pkg::ALL_ONES : hb_sum[TW-1:0];
        rx_deadline   = (rx_sum[TW] || rx_span_reg == hdt_pkg::ALL_ONES)
                        ? hdt_pkg::ALL_ONES : rx_sum[TW-1:0];
    end

    // Update deadlines for start, receive and ping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_ping_reg <= '0;
            hb_expiry_reg <= '0;
            rx_expiry_reg <= '0;
        end
        else if (s1_advance)
        begin
            case (s1_action_reg) inside
                hdt_pkg::ACT_START,
                hdt_pkg::ACT_RECEIVE:
                begin
                    next_ping_reg <= ping_deadline;
                    hb_expiry_reg <= hb_deadline;
                    rx_expiry_reg <= rx_deadline;
                end
                hdt_pkg::ACT_PING:
                begin
                    next_ping_reg <= ping_deadline;
                end
                default: ;
            endcase
        end
    end

    // Poll decision in priority order
    always_comb
    begin
        min_ph    = (hb_expiry_reg < next_ping_reg) ? hb_expiry_reg : next_ping_reg;
        wake_next = '0;
        if (ping_span_reg == '0 || hb_span_reg == '0)
        begin
            dec_next = hdt_pkg::DEC_RX_EXPIRED;
        end
        else if (hb_expiry_reg <= s1_now_reg)
        begin
            dec_next = hdt_pkg::DEC_HB_EXPIRED;
        end
        else if (rx_expiry_reg <= s1_now_reg)
        begin
            dec_next = hdt_pkg::DEC_RX_EXPIRED;
        end
        else if (next_ping_reg <= s1_now_reg)
        begin
            dec_next = hdt_pkg::DEC_SEND_PING;
        end
        else
        begin
            dec_next  = hdt_pkg::DEC_WAIT;
            wake_next = (rx_expiry_reg < min_ph) ? rx_expiry_reg : min_ph;
        end
    end

    // Result register
    always_comb
    begin
        if (s1_advance && s1_poll)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_poll)
        begin
            out_decision_reg <= dec_next;
            out_wake_reg     <= wake_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.decision     = out_decision_reg;
    assign result.wake_time_ns = out_wake_reg;

endmodule
